>>> rtl/core/sadg_pkg.sv
// ---------------------------------------------------------------------------
// sadg_pkg
// Shared types, codes and the divider step of the strided address generator.
// ---------------------------------------------------------------------------
`default_nettype none

package sadg_pkg;

   localparam int FIELD_DIMS = 4;
   localparam int SIZE_W     = 16;
   localparam int STRIDE_W   = 32;
   localparam int ADDR_W     = 32;
   localparam int RAVEL_W    = 32;
   localparam int RANK_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DQ_W       = SIZE_W + RAVEL_W;
   localparam int DIV_STEPS  = RAVEL_W;

   // Commands
   localparam logic CMD_INDEX = 1'b0;
   localparam logic CMD_RAVEL = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VIEW_RANK     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIM_SIZES     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDES_OUTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_STRIDES_INNER = 3'd4;

   // One transaction in flight along the chain
   typedef struct packed {
      logic                         cmd;
      logic [RAVEL_W-1:0]           t_orig;
      logic [DQ_W-1:0]              dq;     // remainder above, quotient below
      logic [FIELD_DIMS*SIZE_W-1:0] idx;
      logic [ADDR_W-1:0]            addr;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } slot_type;

   // One restoring division step: shift in a dividend bit, subtract if fits
   function automatic logic [DQ_W-1:0] div_step(input logic [DQ_W-1:0] dq,
                                                 input logic [SIZE_W-1:0] size);
      logic [DQ_W:0]     sh;
      logic [SIZE_W:0]   top;
      logic [DQ_W-1:0]   res;
      sh  = {dq, 1'b0};
      top = sh[DQ_W:RAVEL_W];
      res = sh[DQ_W-1:0];
      if (top >= {1'b0, size}) begin
         top = top - {1'b0, size};
         res = {top[SIZE_W-1:0], sh[RAVEL_W-1:1], 1'b1};
      end
      return res;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/sadg_req_if.sv
// ---------------------------------------------------------------------------
// sadg_req_if
// Request channel: command, ravel position and index vector.
// ---------------------------------------------------------------------------
`default_nettype none

interface sadg_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [sadg_pkg::RAVEL_W-1:0]  ravel_position;
   logic [sadg_pkg::SIZE_W-1:0]   dim_index_0;
   logic [sadg_pkg::SIZE_W-1:0]   dim_index_1;
   logic [sadg_pkg::SIZE_W-1:0]   dim_index_2;
   logic [sadg_pkg::SIZE_W-1:0]   dim_index_3;

   modport source (output valid, command, ravel_position,
                   dim_index_0, dim_index_1, dim_index_2, dim_index_3,
                   input ready);
   modport sink   (input valid, command, ravel_position,
                   dim_index_0, dim_index_1, dim_index_2, dim_index_3,
                   output ready);
endinterface

`default_nettype wire

>>> rtl/core/sadg_rsp_if.sv
// ---------------------------------------------------------------------------
// sadg_rsp_if
// Response channel: one word address per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface sadg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [sadg_pkg::ADDR_W-1:0] word_address;

   modport source (output valid, word_address, input ready);
   modport sink   (input valid, word_address, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sadg_cell.sv
// ---------------------------------------------------------------------------
// sadg_cell
// One dimension: pipelined digit extraction, stride multiply, accumulate.
// ---------------------------------------------------------------------------
`default_nettype none

module sadg_cell #(
   parameter int DIM = 0
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 advance,
   input  wire  [sadg_pkg::RANK_W-1:0]         rank,
   input  wire  [sadg_pkg::SIZE_W-1:0]         size,
   input  wire  [sadg_pkg::STRIDE_W-1:0]       stride,
   input  wire  sadg_pkg::slot_type            in_slot,
   output sadg_pkg::slot_type                  out_slot
);

   localparam int STEPS = sadg_pkg::DIV_STEPS;

   sadg_pkg::slot_type stage_ff [0:STEPS];
   sadg_pkg::slot_type prod_slot_ff;
   logic [sadg_pkg::ADDR_W-1:0] prod_ff;
   sadg_pkg::slot_type out_ff;

   logic                                active;
   logic                                divide;
   logic [sadg_pkg::SIZE_W-1:0]         digit;
   logic [sadg_pkg::RAVEL_W-1:0]        t_next;
   sadg_pkg::item_type                  fin;
   sadg_pkg::item_type                  acc_in;
   logic [sadg_pkg::SIZE_W+sadg_pkg::STRIDE_W-1:0] prod_in;

   // Dividend enters the first stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0].valid <= 1'b0;
      end else if (advance) begin
         stage_ff[0].valid <= in_slot.valid;
      end
      if (advance) begin
         stage_ff[0].item <= in_slot.item;
      end
   end

   // One quotient bit per stage
   for (genvar s = 0; s < STEPS; s++) begin : g_div
      sadg_pkg::item_type stage_in;

      always_comb begin
         stage_in    = stage_ff[s].item;
         stage_in.dq = sadg_pkg::div_step(stage_ff[s].item.dq, size);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[s+1].valid <= 1'b0;
         end else if (advance) begin
            stage_ff[s+1].valid <= stage_ff[s].valid;
         end
         if (advance) begin
            stage_ff[s+1].item <= stage_in;
         end
      end
   end

   // Pick digit and quotient handed to the next dimension
   always_comb begin
      active = (rank > sadg_pkg::RANK_W'(DIM));
      divide = active && (stage_ff[STEPS].item.cmd == sadg_pkg::CMD_RAVEL) &&
               (size != '0);
      fin    = stage_ff[STEPS].item;
      if (!active) begin
         digit = '0;
      end else if (fin.cmd == sadg_pkg::CMD_RAVEL) begin
         digit = divide ? fin.dq[sadg_pkg::DQ_W-1:sadg_pkg::RAVEL_W] : '0;
      end else begin
         digit = fin.idx[DIM*sadg_pkg::SIZE_W +: sadg_pkg::SIZE_W];
      end
      t_next     = divide ? fin.dq[sadg_pkg::RAVEL_W-1:0] : fin.t_orig;
      fin.t_orig = t_next;
      fin.dq     = {{sadg_pkg::SIZE_W{1'b0}}, t_next};
      prod_in    = digit * stride;
   end

   // Add the registered product to the running address
   always_comb begin
      acc_in      = prod_slot_ff.item;
      acc_in.addr = prod_slot_ff.item.addr + prod_ff;
   end

   // Register the product, then accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_slot_ff.valid <= 1'b0;
         out_ff.valid       <= 1'b0;
      end else if (advance) begin
         prod_slot_ff.valid <= stage_ff[STEPS].valid;
         out_ff.valid       <= prod_slot_ff.valid;
      end
      if (advance) begin
         prod_slot_ff.item <= fin;
         prod_ff           <= prod_in[sadg_pkg::ADDR_W-1:0];
         out_ff.item       <= acc_in;
      end
   end

   assign out_slot = out_ff;

endmodule

`default_nettype wire

>>> rtl/core/strided_array_address_generator_top.sv
// ---------------------------------------------------------------------------
// strided_array_address_generator_top
// Word address of an element of a strided multi-dimensional array view.
// ---------------------------------------------------------------------------
// One request is accepted every cycle while the chain advances, and yields one
// address. Requests walk a chain of dimension cells, innermost dimension first;
// each cell holds a 32-stage restoring divider, a multiply stage and an
// accumulate stage, with min(MAX_RANK,4) cells in the chain. The whole chain
// stalls only while a finished address waits on the response side.
`default_nettype none

module strided_array_address_generator_top #(
   parameter int MAX_RANK = 4
) (
   input  wire                                 clock,
   input  wire                                 reset,
   sadg_req_if.sink                            req_bus,
   sadg_rsp_if.source                          rsp_bus,
   input  wire                                 csr_write_enable,
   input  wire  [sadg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [sadg_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int NCELL = (MAX_RANK < sadg_pkg::FIELD_DIMS) ? MAX_RANK
                                                            : sadg_pkg::FIELD_DIMS;

   logic [sadg_pkg::RANK_W-1:0]   view_rank_ff;
   logic [sadg_pkg::ADDR_W-1:0]   base_offset_ff;
   logic [63:0]                   dim_sizes_ff;
   logic [63:0]                   strides_outer_ff;
   logic [63:0]                   strides_inner_ff;

   logic               advance;
   sadg_pkg::slot_type head;
   sadg_pkg::slot_type chain [0:NCELL];

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         view_rank_ff     <= 3'd1;
         base_offset_ff   <= '0;
         dim_sizes_ff     <= 64'h0001_0001_0001_0001;
         strides_outer_ff <= 64'd1;
         strides_inner_ff <= 64'd1;
      end else if (csr_write_enable) begin
         case (csr_index)
            sadg_pkg::REG_VIEW_RANK:     view_rank_ff     <= csr_data[sadg_pkg::RANK_W-1:0];
            sadg_pkg::REG_BASE_OFFSET:   base_offset_ff   <= csr_data[sadg_pkg::ADDR_W-1:0];
            sadg_pkg::REG_DIM_SIZES:     dim_sizes_ff     <= csr_data;
            sadg_pkg::REG_STRIDES_OUTER: strides_outer_ff <= csr_data;
            sadg_pkg::REG_STRIDES_INNER: strides_inner_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance the chain unless the result waits
   assign advance       = !rsp_bus.valid || rsp_bus.ready;
   assign req_bus.ready = advance;

   // Build the transaction entering the chain
   always_comb begin
      head.valid       = req_bus.valid;
      head.item.cmd    = req_bus.command;
      head.item.t_orig = req_bus.ravel_position;
      head.item.dq     = {{sadg_pkg::SIZE_W{1'b0}}, req_bus.ravel_position};
      head.item.idx    = {req_bus.dim_index_3, req_bus.dim_index_2,
                          req_bus.dim_index_1, req_bus.dim_index_0};
      head.item.addr   = base_offset_ff;
   end

   assign chain[0] = head;

   // Innermost dimension first
   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      localparam int D = NCELL - 1 - k;
      logic [sadg_pkg::STRIDE_W-1:0] stride;
      if (D == 0)      begin : g_s0 assign stride = strides_outer_ff[31:0];  end
      else if (D == 1) begin : g_s1 assign stride = strides_outer_ff[63:32]; end
      else if (D == 2) begin : g_s2 assign stride = strides_inner_ff[31:0];  end
      else             begin : g_s3 assign stride = strides_inner_ff[63:32]; end

      sadg_cell #(.DIM(D)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .rank     (view_rank_ff),
         .size     (dim_sizes_ff[D*sadg_pkg::SIZE_W +: sadg_pkg::SIZE_W]),
         .stride   (stride),
         .in_slot  (chain[k]),
         .out_slot (chain[k+1])
      );
   end

   assign rsp_bus.valid        = chain[NCELL].valid;
   assign rsp_bus.word_address = chain[NCELL].item.addr;

   // Checks
   a_accept_only_when_moving: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("request accepted while chain stalled");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_bus.valid)
      else $error("result valid right after reset");

   a_stall_holds_addr: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(chain[NCELL].item.addr))
      else $error("address changed while stalled");

endmodule

`default_nettype wire

>>> test/strided_array_address_generator_top_tb.sv
// ---------------------------------------------------------------------------
// strided_array_address_generator_top_tb
// Self-checking bench for the strided array address generator. Requests go
// out in random bursts under several view settings; every returned word
// address is compared in order against an address computed here from a
// shadow copy of the view registers.
// ---------------------------------------------------------------------------
`default_nettype none

module strided_array_address_generator_top_tb;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_enable;
   logic [sadg_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sadg_pkg::CSR_DATA_W-1:0] csr_data;

   sadg_req_if req_bus ();
   sadg_rsp_if rsp_bus ();

   strided_array_address_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Shadow of the view registers
   logic [sadg_pkg::RANK_W-1:0]     view_rank_q;
   logic [sadg_pkg::ADDR_W-1:0]     base_offset_q;
   logic [63:0]                     dim_sizes_q;
   logic [63:0]                     strides_outer_q;
   logic [63:0]                     strides_inner_q;

   logic [sadg_pkg::ADDR_W-1:0]     pending_addresses[$];
   int                              error_count;
   int                              burst_left;
   int                              stall_percent;
   bit                              hold_request;
   int                              hold_left;

   // Clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Address a request should produce under the current view
   function automatic logic [sadg_pkg::ADDR_W-1:0] predict_word_address(
         input logic cmd, input logic [sadg_pkg::RAVEL_W-1:0] ravel,
         input logic [4*sadg_pkg::SIZE_W-1:0] index_vector);
      int                            rank;
      logic [31:0]                   digit[4];
      logic [31:0]                   quotient;
      logic [31:0]                   size;
      logic [63:0]                   pair;
      logic [sadg_pkg::ADDR_W-1:0]   addr;
      rank = (view_rank_q > 4) ? 4 : int'(view_rank_q);
      for (int d = 0; d < 4; d++) digit[d] = '0;
      if (cmd == sadg_pkg::CMD_INDEX) begin
         for (int d = 0; d < rank; d++) digit[d] = 32'(index_vector[16*d +: 16]);
      end else begin
         quotient = ravel;
         // split innermost first; a zero size yields digit zero
         for (int d = rank - 1; d >= 0; d--) begin
            size = 32'(dim_sizes_q[16*d +: 16]);
            if (size != 0) begin
               digit[d] = quotient % size;
               quotient = quotient / size;
            end
         end
      end
      addr = base_offset_q;
      for (int d = 0; d < rank; d++) begin
         pair = d[1] ? strides_inner_q : strides_outer_q;
         addr = addr + digit[d] * pair[32*d[0] +: 32];
      end
      return addr;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] expected_value,
                                  input logic [31:0] actual_value);
      $display("mismatch %s: expected %h, got %h at %0t", what, expected_value,
               actual_value, $realtime);
      error_count++;
   endtask

   // Send one request transaction, with random gaps between bursts
   task automatic send_request(input logic cmd, input logic [sadg_pkg::RAVEL_W-1:0] ravel,
                               input logic [4*sadg_pkg::SIZE_W-1:0] index_vector);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_bus.valid          <= 1'b1;
      req_bus.command        <= cmd;
      req_bus.ravel_position <= ravel;
      req_bus.dim_index_0    <= index_vector[15:0];
      req_bus.dim_index_1    <= index_vector[31:16];
      req_bus.dim_index_2    <= index_vector[47:32];
      req_bus.dim_index_3    <= index_vector[63:48];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_addresses.push_back(predict_word_address(cmd, ravel, index_vector));
      burst_left--;
   endtask

   // Stop sending and wait for every outstanding address
   task automatic drain;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (pending_addresses.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [sadg_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [sadg_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         sadg_pkg::REG_VIEW_RANK:     view_rank_q     = data[sadg_pkg::RANK_W-1:0];
         sadg_pkg::REG_BASE_OFFSET:   base_offset_q   = data[31:0];
         sadg_pkg::REG_DIM_SIZES:     dim_sizes_q     = data;
         sadg_pkg::REG_STRIDES_OUTER: strides_outer_q = data;
         sadg_pkg::REG_STRIDES_INNER: strides_inner_q = data;
         default: ;
      endcase
   endtask

   task automatic write_view(input logic [2:0] rank, input logic [31:0] base,
                             input logic [63:0] sizes, input logic [63:0] outer,
                             input logic [63:0] inner);
      write_register(sadg_pkg::REG_VIEW_RANK, 64'(rank));
      write_register(sadg_pkg::REG_BASE_OFFSET, 64'(base));
      write_register(sadg_pkg::REG_DIM_SIZES, sizes);
      write_register(sadg_pkg::REG_STRIDES_OUTER, outer);
      write_register(sadg_pkg::REG_STRIDES_INNER, inner);
   endtask

   function automatic logic [15:0] pick_size();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3: return 16'($urandom);
         default: return 16'($urandom_range(2, 9));
      endcase
   endfunction

   function automatic logic [31:0] pick_stride();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return 32'($urandom_range(0, 64)) - 32'd16;
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else if (hold_request && hold_left == 0) begin
         hold_request = 1'b0;
         hold_left = 400;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= stall_percent);
      end
   end

   // Compare each returned address with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_addresses.size() == 0) begin
            report_mismatch("unexpected word_address", '0, rsp_bus.word_address);
         end else begin
            logic [31:0] expected_address;
            expected_address = pending_addresses.pop_front();
            if (rsp_bus.word_address !== expected_address)
               report_mismatch("word_address", expected_address, rsp_bus.word_address);
         end
      end
   end

   task automatic test_reset_view;
      send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'h0);
      send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(sadg_pkg::CMD_RAVEL, 32'hFFFF_FFFF, 64'h0);
      drain();
   endtask

   task automatic test_index_extremes;
      write_view(3'd4, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 {32'hFFFF_FFFF, 32'h8000_0000}, {32'h0000_0001, 32'h7FFF_FFFF});
      send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'h0);
      send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_request(sadg_pkg::CMD_INDEX, 32'hFFFF_FFFF, 64'h0001_8000_FFFF_0001);
      send_request(sadg_pkg::CMD_RAVEL, 32'hFFFF_FFFF, 64'h0);
      send_request(sadg_pkg::CMD_RAVEL, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
      drain();
   endtask

   // Zero sizes, leftover quotient, indices past their size
   task automatic test_ravel_special;
      write_view(3'd4, 32'h0000_1000, 64'h0003_0000_0005_0002,
                 {32'd100, 32'd1000}, {32'hFFFF_FFFD, 32'd7});
      send_request(sadg_pkg::CMD_RAVEL, 32'd0, 64'h0);
      send_request(sadg_pkg::CMD_RAVEL, 32'd29, 64'h0);
      send_request(sadg_pkg::CMD_RAVEL, 32'd31, 64'h0);
      send_request(sadg_pkg::CMD_RAVEL, 32'hFFFF_FFFF, 64'h0);
      send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'h0009_0007_0005_0003);
      drain();
   endtask

   // Ranks zero through seven, including those above the maximum
   task automatic test_rank_sweep;
      for (int r = 0; r < 8; r++) begin
         write_register(sadg_pkg::REG_VIEW_RANK, 64'(r));
         send_request(sadg_pkg::CMD_INDEX, 32'd0, 64'h0004_0003_0002_0001);
         send_request(sadg_pkg::CMD_RAVEL, 32'd12345, 64'h0);
         drain();
      end
   endtask

   task automatic send_random_request;
      logic [63:0] index_vector;
      logic [31:0] ravel;
      index_vector = {$urandom, $urandom};
      if ($urandom_range(0, 1)) index_vector &= 64'h000F_000F_000F_000F;
      ravel = $urandom;
      if ($urandom_range(0, 1)) ravel = $urandom_range(0, 300);
      send_request(1'($urandom), ravel, index_vector);
   endtask

   task automatic test_random_views;
      for (int phase = 0; phase < 10; phase++) begin
         write_view((phase == 0) ? 3'd0 : (phase == 1) ? 3'd7 :
                    ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4)),
                    (phase == 2) ? 32'hFFFF_FFFF : $urandom,
                    (phase == 3) ? {$urandom, $urandom} :
                       {pick_size(), pick_size(), pick_size(), pick_size()},
                    {pick_stride(), pick_stride()}, {pick_stride(), pick_stride()});
         stall_percent = (phase % 3 == 0) ? 0 : $urandom_range(10, 60);
         repeat (20) send_random_request();
         drain();
      end
   endtask

   // Hold the receiver off long enough that the pipeline backs up
   task automatic test_backpressure;
      stall_percent = 20;
      hold_request = 1'b1;
      repeat (300) send_random_request();
      drain();
   endtask

   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_bus.valid          = 1'b0;
      req_bus.command        = sadg_pkg::CMD_INDEX;
      req_bus.ravel_position = '0;
      req_bus.dim_index_0    = '0;
      req_bus.dim_index_1    = '0;
      req_bus.dim_index_2    = '0;
      req_bus.dim_index_3    = '0;
      rsp_bus.ready          = 1'b0;
      view_rank_q     = 3'd1;
      base_offset_q   = '0;
      dim_sizes_q     = 64'h0001_0001_0001_0001;
      strides_outer_q = 64'd1;
      strides_inner_q = 64'd1;
      error_count   = 0;
      burst_left    = 0;
      stall_percent = 0;
      hold_request  = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_view();
      test_index_extremes();
      test_ravel_special();
      test_rank_sweep();
      test_random_views();
      test_backpressure();

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire
